// ===== rtl/i2c_register_access_master_core_defines.svh =====
// assertion macros used by the back end of the i2c register access master rtl
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define I2CRAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2CRAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2cram_pkg.sv =====
// types and constants of the i2c register access master
package i2cram_pkg;

    localparam logic [1:0]  ACT_WRITE       = 2'd1;
    localparam logic [1:0]  ACT_READ        = 2'd2;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd20;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SA,
        ST_SB,
        ST_SC,
        ST_TXSET,
        ST_TXHIGH,
        ST_TXLOW,
        ST_TXREL,
        ST_ACKREL,
        ST_ACKHIGH,
        ST_ACKLOW,
        ST_RXREL,
        ST_RXHIGH,
        ST_RXLOW,
        ST_NKSET,
        ST_NKHIGH,
        ST_NKLOW,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_PD
    } t_step;

    // which byte of the transaction is on the bus
    typedef enum logic [1:0] {
        STG_DEV,
        STG_REG,
        STG_DATA,
        STG_RDEV
    } t_stage;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] dev_byte;
        logic [7:0] reg_byte;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic scl;
        logic sda;
    } t_lines;

endpackage

// ===== rtl/i2cram_if.sv =====
// valid/ready channel interfaces for the input ticks and the results
interface i2cram_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] dev_byte;
    logic [7:0] reg_byte;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output action, output dev_byte, output reg_byte,
                    output write_data, output sda_in, input ready);
    modport sink (input valid, input action, input dev_byte, input reg_byte,
                  input write_data, input sda_in, output ready);
endinterface

interface i2cram_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output ack_ok, output read_data, input ready);
    modport sink (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input ack_ok, input read_data, output ready);
endinterface

// ===== rtl/i2cram_front.sv =====
// front end: takes input items and classifies the requested action
module i2cram_front
    import i2cram_pkg::*;
(
    i2cram_in_if.sink i_in,
    input  logic      i_q_ready,
    output logic      o_q_valid,
    output t_item     o_q_item
);

    assign i_in.ready = i_q_ready;
    assign o_q_valid  = i_in.valid;

    always_comb begin
        o_q_item.dev_byte   = i_in.dev_byte;
        o_q_item.reg_byte   = i_in.reg_byte;
        o_q_item.write_data = i_in.write_data;
        o_q_item.sda_in     = i_in.sda_in;
        case (i_in.action)
            ACT_WRITE: begin
                o_q_item.cmd = CMD_WRITE;
            end
            ACT_READ: begin
                o_q_item.cmd = CMD_READ;
            end
            default: begin
                o_q_item.cmd = CMD_TICK;
            end
        endcase
    end

endmodule

// ===== rtl/i2cram_fifo.sv =====
// short item queue between the front end and the bus sequencer
module i2cram_fifo
    import i2cram_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    input  t_item i_wr_item,
    output logic  o_wr_ready,
    output logic  o_rd_valid,
    output t_item o_rd_item,
    input  logic  i_rd_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            push, pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/i2cram_back.sv =====
// back end: i2c bus sequencer, one queued tick per cycle while the result output is taken, registered result
`include "i2c_register_access_master_core_defines.svh"

module i2cram_back
    import i2cram_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [15:0]  i_phase_ticks,
    input  logic         i_q_valid,
    input  t_item        i_q_item,
    output logic         o_q_ready,
    i2cram_out_if.source o_out
);

    t_step       r_step,       n_step;
    t_stage      r_stage,      n_stage;
    logic [15:0] r_phase,      n_phase;
    logic [3:0]  r_bit_cnt,    n_bit_cnt;
    logic [7:0]  r_shift,      n_shift;
    logic [7:0]  r_dev,        n_dev;
    logic [7:0]  r_reg,        n_reg;
    logic [7:0]  r_wdata,      n_wdata;
    logic        r_read_mode,  n_read_mode;
    logic        r_scl,        n_scl;
    logic        r_sda,        n_sda;
    logic        r_nack,       n_nack;
    logic        r_out_valid,  n_out_valid;
    t_result     r_out,        n_out;
    logic        fire;

    // line levels on entry to a step
    function automatic t_lines lines_for(t_step s, logic msb, logic cur_sda);
        t_lines l;
        case (s)
            ST_IDLE, ST_SA, ST_PD: begin
                l = '{scl: 1'b1, sda: 1'b1};
            end
            ST_SB, ST_PC: begin
                l = '{scl: 1'b1, sda: 1'b0};
            end
            ST_SC, ST_PB: begin
                l = '{scl: 1'b0, sda: 1'b0};
            end
            ST_TXSET, ST_TXLOW: begin
                l = '{scl: 1'b0, sda: msb};
            end
            ST_TXHIGH: begin
                l = '{scl: 1'b1, sda: msb};
            end
            ST_ACKHIGH, ST_RXHIGH, ST_NKHIGH: begin
                l = '{scl: 1'b1, sda: 1'b1};
            end
            ST_PA: begin
                l = '{scl: 1'b0, sda: cur_sda};
            end
            default: begin
                l = '{scl: 1'b0, sda: 1'b1};
            end
        endcase
        return l;
    endfunction

    assign o_q_ready = !r_out_valid || o_out.ready;
    assign fire      = i_q_valid && o_q_ready;

    always_comb begin
        logic [15:0] len;
        logic        done;
        logic        scl_o;
        logic        sda_o;
        t_step       nxt;
        t_lines      lines;

        n_step      = r_step;
        n_stage     = r_stage;
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_wdata     = r_wdata;
        n_read_mode = r_read_mode;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_nack      = r_nack;
        n_out       = r_out;
        n_out_valid = o_out.ready ? 1'b0 : r_out_valid;
        len         = (i_phase_ticks == '0) ? 16'd1 : i_phase_ticks;
        done        = 1'b0;
        scl_o       = r_scl;
        sda_o       = r_sda;
        nxt         = r_step;
        lines       = '{scl: r_scl, sda: r_sda};

        if (fire) begin
            // a start is honored only while idle
            if (r_step == ST_IDLE &&
                (i_q_item.cmd == CMD_WRITE || i_q_item.cmd == CMD_READ)) begin
                n_dev       = i_q_item.dev_byte;
                n_reg       = i_q_item.reg_byte;
                n_wdata     = i_q_item.write_data;
                n_read_mode = (i_q_item.cmd == CMD_READ);
                n_nack      = 1'b0;
                n_stage     = STG_DEV;
                n_bit_cnt   = '0;
                n_shift     = '0;
                n_step      = ST_SA;
                n_phase     = '0;
                n_scl       = 1'b1;
                n_sda       = 1'b1;
            end

            scl_o = n_scl;
            sda_o = n_sda;

            if (n_step != ST_IDLE) begin
                if ({1'b0, n_phase} + 17'd1 >= {1'b0, len}) begin
                    n_phase = '0;
                    case (n_step)
                        ST_SA: begin
                            nxt = ST_SB;
                        end
                        ST_SB: begin
                            nxt = ST_SC;
                        end
                        ST_SC: begin
                            n_shift   = {n_dev[7:1], (n_stage == STG_RDEV)};
                            n_bit_cnt = '0;
                            nxt       = ST_TXSET;
                        end
                        ST_TXSET: begin
                            nxt = ST_TXHIGH;
                        end
                        ST_TXHIGH: begin
                            nxt = ST_TXLOW;
                        end
                        ST_TXLOW: begin
                            n_shift   = {n_shift[6:0], 1'b0};
                            n_bit_cnt = n_bit_cnt + 4'd1;
                            nxt       = (n_bit_cnt >= BITS_PER_BYTE) ? ST_TXREL : ST_TXSET;
                        end
                        ST_TXREL: begin
                            nxt = ST_ACKREL;
                        end
                        ST_ACKREL: begin
                            nxt = ST_ACKHIGH;
                        end
                        ST_ACKHIGH: begin
                            if (i_q_item.sda_in) begin
                                n_nack = 1'b1;
                            end
                            nxt = ST_ACKLOW;
                        end
                        ST_ACKLOW: begin
                            if (n_nack) begin
                                nxt = ST_PA;
                            end else if (n_stage == STG_DEV) begin
                                n_stage   = STG_REG;
                                n_shift   = n_reg;
                                n_bit_cnt = '0;
                                nxt       = ST_TXSET;
                            end else if (n_stage == STG_REG) begin
                                if (n_read_mode) begin
                                    // repeated start, then address for reading
                                    n_stage = STG_RDEV;
                                    nxt     = ST_SA;
                                end else begin
                                    n_stage   = STG_DATA;
                                    n_shift   = n_wdata;
                                    n_bit_cnt = '0;
                                    nxt       = ST_TXSET;
                                end
                            end else if (n_stage == STG_DATA) begin
                                nxt = ST_PA;
                            end else begin
                                n_shift   = '0;
                                n_bit_cnt = '0;
                                nxt       = ST_RXREL;
                            end
                        end
                        ST_RXREL: begin
                            nxt = ST_RXHIGH;
                        end
                        ST_RXHIGH: begin
                            n_shift = {n_shift[6:0], i_q_item.sda_in};
                            nxt     = ST_RXLOW;
                        end
                        ST_RXLOW: begin
                            n_bit_cnt = n_bit_cnt + 4'd1;
                            nxt       = (n_bit_cnt >= BITS_PER_BYTE) ? ST_NKSET : ST_RXHIGH;
                        end
                        ST_NKSET: begin
                            nxt = ST_NKHIGH;
                        end
                        ST_NKHIGH: begin
                            nxt = ST_NKLOW;
                        end
                        ST_NKLOW: begin
                            nxt = ST_PA;
                        end
                        ST_PA: begin
                            nxt = ST_PB;
                        end
                        ST_PB: begin
                            nxt = ST_PC;
                        end
                        ST_PC: begin
                            nxt = ST_PD;
                        end
                        default: begin
                            nxt  = ST_IDLE;
                            done = 1'b1;
                        end
                    endcase
                    lines  = lines_for(nxt, n_shift[7], n_sda);
                    n_step = nxt;
                    n_scl  = lines.scl;
                    n_sda  = lines.sda;
                end else begin
                    n_phase = n_phase + 16'd1;
                end
            end

            n_out_valid       = 1'b1;
            n_out.scl_out     = scl_o;
            n_out.sda_out     = sda_o;
            n_out.busy_res    = (n_step != ST_IDLE);
            n_out.done_res    = done;
            n_out.ack_ok      = done && !n_nack;
            n_out.read_data   = (done && !n_nack && n_read_mode) ? n_shift : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_stage     <= STG_DEV;
            r_phase     <= '0;
            r_bit_cnt   <= '0;
            r_read_mode <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_nack      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_stage     <= n_stage;
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_read_mode <= n_read_mode;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_nack      <= n_nack;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_dev   <= n_dev;
        r_reg   <= n_reg;
        r_wdata <= n_wdata;
        r_out   <= n_out;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_out.scl_out;
    assign o_out.sda_out   = r_out.sda_out;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.done_res  = r_out.done_res;
    assign o_out.ack_ok    = r_out.ack_ok;
    assign o_out.read_data = r_out.read_data;

    `I2CRAM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n,
        r_out_valid && r_out.done_res, !r_out.busy_res, "done item still reports busy")
    `I2CRAM_ASSERT_NOW(a_ack_needs_done, i_clk, i_rst_n,
        r_out_valid && r_out.ack_ok, r_out.done_res, "ack_ok without done")
    `I2CRAM_ASSERT_NOW(a_bit_cnt_range, i_clk, i_rst_n,
        1'b1, r_bit_cnt <= BITS_PER_BYTE, "bit counter past one byte")
    `I2CRAM_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n,
        fire && r_step == ST_IDLE && (i_q_item.cmd == CMD_WRITE || i_q_item.cmd == CMD_READ),
        r_step != ST_IDLE && r_out_valid, "start did not leave idle")

endmodule

// ===== rtl/i2c_register_access_master_core.sv =====
// i2c register access master: one input item per tick, one result item per input item
// an accepted input item passes through the queue, then the result register, before its result item is valid
// throughput: 1 item per cycle sustained while the result output is taken; the sequencer advances one bus tick per item
// the phase length register sets ticks per bus phase, not cycles per item
// reset (synchronous): sequencer idle with both lines released, queue empty, phase_ticks 20
module i2c_register_access_master_core
    import i2cram_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    i2cram_in_if.sink    i_in,
    i2cram_out_if.source o_out
);

    logic [15:0] r_phase_ticks;
    logic        push_valid, push_ready;
    t_item       push_item;
    logic        pop_valid, pop_ready;
    t_item       pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    i2cram_front u_front (
        .i_in      (i_in),
        .i_q_ready (push_ready),
        .o_q_valid (push_valid),
        .o_q_item  (push_item)
    );

    i2cram_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push_valid),
        .i_wr_item  (push_item),
        .o_wr_ready (push_ready),
        .o_rd_valid (pop_valid),
        .o_rd_item  (pop_item),
        .i_rd_ready (pop_ready)
    );

    i2cram_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_q_valid     (pop_valid),
        .i_q_item      (pop_item),
        .o_q_ready     (pop_ready),
        .o_out         (o_out)
    );

endmodule
